// ===== rtl/rvd_pkg.sv =====
package rvd_pkg;

	typedef enum logic [6:0] {
		OP_INV = 7'd0,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_LB_MMU, OP_LH_MMU, OP_LW_MMU, OP_LBU_MMU, OP_LHU_MMU,
		OP_SB, OP_SH, OP_SW, OP_SB_MMU, OP_SH_MMU, OP_SW_MMU,
		OP_P_INC, OP_P_DEC, OP_C_ADDI, OP_C_ANDI, OP_C_SLLI, OP_C_SRAI, OP_C_SRLI,
		OP_P_LI_0, OP_P_LI_1, OP_C_LI, OP_C_MV, OP_ADDI,
		OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI,
		OP_AUIPC, OP_LUI,
		OP_C_ADD, OP_C_SUB, OP_C_XOR, OP_C_OR, OP_C_AND,
		OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND, OP_SUB, OP_SRA,
		OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU,
		OP_C_BEQZ, OP_C_BNEZ, OP_P_BLTZ, OP_P_BGEZ, OP_P_BGTZ, OP_P_BLEZ,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_C_J, OP_C_JAL, OP_JAL,
		OP_P_RET, OP_C_JR, OP_JALR,
		OP_TRAP,
		OP_ECALL, OP_SRET, OP_SFENCE_VMA, OP_CSRRW, OP_CSRRS
	} op_e_t;

	typedef enum logic [1:0] {
		CLS_NORMAL   = 2'd0,
		CLS_JUMP     = 2'd1,
		CLS_BRANCH   = 2'd2,
		CLS_INDIRECT = 2'd3
	} cls_t;

	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_TRAP   = 7'h6b;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [2:0] F3_B    = 3'd0;
	localparam logic [2:0] F3_H    = 3'd1;
	localparam logic [2:0] F3_W    = 3'd2;
	localparam logic [2:0] F3_BU   = 3'd4;
	localparam logic [2:0] F3_HU   = 3'd5;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_PRIV  = 3'd0;
	localparam logic [2:0] F3_CSRRW = 3'd1;
	localparam logic [2:0] F3_CSRRS = 3'd2;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;

	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_SRET   = 12'h102;
	localparam logic [11:0] SYS_SFENCE = 12'h120;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd1;

	typedef struct packed {
		op_e_t       op;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [4:0]  rd;
		logic        discard;
		logic [31:0] imm_a;
		logic [31:0] imm_b;
		cls_t        cls;
		logic [31:0] target;
	} dec_t;

endpackage

// ===== rtl/rv32im_instruction_decoder.sv =====
// RV32IM instruction decoder.
// An instruction transaction is taken at a rising edge where start is high and
// busy is low; busy is never raised, so one instruction can be taken every
// cycle. instr_word and pc are captured in an input register, decoded by one
// level of combinational logic and stored in the result register.
// Each result is presented once its instruction has passed the input register
// and then the result register. It is valid
// for exactly one cycle, marked by done. The receiver cannot stall the block,
// so results leave at the same rate as instructions arrive: one per cycle.
// The decode path is a handful of field compares plus the 32-bit additions for
// the branch, jump and auipc targets and the jal return address, all within the
// combinational logic between the input and result registers.
// The configuration channel carries the translated-access flag; cfg_ready is
// always high and a write is taken when cfg_valid is high. It is to be
// written only while no instruction is in flight.
// Asynchronous reset clears the pipeline valid bits and the flag, so no
// result is signalled until a new instruction has been taken.
module rv32im_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instr_word,
	input  logic [31:0] pc,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        done,
	output logic [6:0]  op_id,
	output logic [4:0]  rs1_index,
	output logic [4:0]  rs2_index,
	output logic [4:0]  rd_index,
	output logic        write_discard,
	output logic [31:0] imm_a,
	output logic [31:0] imm_b,
	output logic [1:0]  instr_class,
	output logic [31:0] jump_target
);
	import rvd_pkg::*;

	logic        mmu_q;
	logic        valid_s1;
	logic [31:0] word_s1;
	logic [31:0] pc_s1;
	logic        valid_s2;
	dec_t        res_s2;
	dec_t        dec;

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [31:0] iimm;
	logic [31:0] simm;
	logic [31:0] bimm;
	logic [31:0] jimm;
	logic [31:0] uimm;
	logic [11:0] sys_imm;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmu_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mmu_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= instr_word;
			pc_s1   <= pc;
		end
		if (valid_s1) begin
			res_s2 <= dec;
		end
	end

	assign opc     = word_s1[6:0];
	assign rd      = word_s1[11:7];
	assign f3      = word_s1[14:12];
	assign rs1     = word_s1[19:15];
	assign rs2     = word_s1[24:20];
	assign f7      = word_s1[31:25];
	assign sys_imm = word_s1[31:20];
	assign iimm    = {{20{word_s1[31]}}, word_s1[31:20]};
	assign simm    = {{20{word_s1[31]}}, word_s1[31:25], word_s1[11:7]};
	assign bimm    = {{19{word_s1[31]}}, word_s1[31], word_s1[7], word_s1[30:25],
		word_s1[11:8], 1'b0};
	assign jimm    = {{11{word_s1[31]}}, word_s1[31], word_s1[19:12], word_s1[20],
		word_s1[30:21], 1'b0};
	assign uimm    = {word_s1[31:12], 12'd0};

	always_comb begin
		dec         = '0;
		dec.op      = OP_INV;
		dec.cls     = CLS_NORMAL;
		unique case (opc)
			OPC_LOAD: begin
				dec.rs1     = rs1;
				dec.imm_b   = iimm;
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				case (f3)
					F3_B:    dec.op = mmu_q ? OP_LB_MMU : OP_LB;
					F3_H:    dec.op = mmu_q ? OP_LH_MMU : OP_LH;
					F3_W:    dec.op = mmu_q ? OP_LW_MMU : OP_LW;
					F3_BU:   dec.op = mmu_q ? OP_LBU_MMU : OP_LBU;
					F3_HU:   dec.op = mmu_q ? OP_LHU_MMU : OP_LHU;
					default: dec.op = OP_INV;
				endcase
			end
			OPC_OP_IMM: begin
				dec.rs1     = rs1;
				dec.imm_b   = iimm;
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				if (rd == rs1) begin
					if (f3 == F3_ADD) begin
						if (iimm == 32'd1) dec.op = OP_P_INC;
						else if (iimm == '1) dec.op = OP_P_DEC;
						else dec.op = OP_C_ADDI;
					end else if (f3 == F3_AND) dec.op = OP_C_ANDI;
					else if (f3 == F3_SLL && f7 == F7_BASE) dec.op = OP_C_SLLI;
					else if (f3 == F3_SR && f7 == F7_ALT) dec.op = OP_C_SRAI;
					else if (f3 == F3_SR && f7 == F7_BASE) dec.op = OP_C_SRLI;
				end
				if (dec.op == OP_INV) begin
					if (f3 == F3_ADD) begin
						if (rs1 == REG_ZERO && iimm == 32'd0) dec.op = OP_P_LI_0;
						else if (rs1 == REG_ZERO && iimm == 32'd1) dec.op = OP_P_LI_1;
						else if (rs1 == REG_ZERO) dec.op = OP_C_LI;
						else if (iimm == 32'd0) dec.op = OP_C_MV;
						else dec.op = OP_ADDI;
					end else if (f3 == F3_SLT) dec.op = OP_SLTI;
					else if (f3 == F3_SLTU) dec.op = OP_SLTIU;
					else if (f3 == F3_XOR) dec.op = OP_XORI;
					else if (f3 == F3_OR) dec.op = OP_ORI;
					else if (f3 == F3_AND) dec.op = OP_ANDI;
					else if (f3 == F3_SLL && f7 == F7_BASE) dec.op = OP_SLLI;
					else if (f3 == F3_SR && f7 == F7_BASE) dec.op = OP_SRLI;
					else if (f3 == F3_SR && f7 == F7_ALT) dec.op = OP_SRAI;
				end
			end
			OPC_AUIPC: begin
				dec.op      = OP_AUIPC;
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				dec.imm_a   = pc_s1 + uimm;
			end
			OPC_LUI: begin
				dec.op      = OP_LUI;
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				dec.imm_a   = uimm;
			end
			OPC_STORE: begin
				dec.rs1   = rs1;
				dec.rs2   = rs2;
				dec.imm_b = simm;
				case (f3)
					F3_B:    dec.op = mmu_q ? OP_SB_MMU : OP_SB;
					F3_H:    dec.op = mmu_q ? OP_SH_MMU : OP_SH;
					F3_W:    dec.op = mmu_q ? OP_SW_MMU : OP_SW;
					default: dec.op = OP_INV;
				endcase
			end
			OPC_OP: begin
				dec.rs1     = rs1;
				dec.rs2     = rs2;
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				if (rd == rs1 && f7 == F7_BASE) begin
					if (f3 == F3_ADD) dec.op = OP_C_ADD;
					else if (f3 == F3_XOR) dec.op = OP_C_XOR;
					else if (f3 == F3_OR) dec.op = OP_C_OR;
					else if (f3 == F3_AND) dec.op = OP_C_AND;
				end
				if (rd == rs1 && f7 == F7_ALT && f3 == F3_ADD) dec.op = OP_C_SUB;
				if (dec.op == OP_INV) begin
					if (f7 == F7_BASE) begin
						case (f3)
							F3_ADD:  dec.op = OP_ADD;
							F3_SLL:  dec.op = OP_SLL;
							F3_SLT:  dec.op = OP_SLT;
							F3_SLTU: dec.op = OP_SLTU;
							F3_XOR:  dec.op = OP_XOR;
							F3_SR:   dec.op = OP_SRL;
							F3_OR:   dec.op = OP_OR;
							default: dec.op = OP_AND;
						endcase
					end else if (f7 == F7_MULDIV) begin
						case (f3)
							F3_ADD:  dec.op = OP_MUL;
							F3_SLL:  dec.op = OP_MULH;
							F3_SLT:  dec.op = OP_MULHSU;
							F3_SLTU: dec.op = OP_MULHU;
							F3_XOR:  dec.op = OP_DIV;
							F3_SR:   dec.op = OP_DIVU;
							F3_OR:   dec.op = OP_REM;
							default: dec.op = OP_REMU;
						endcase
					end else if (f7 == F7_ALT && f3 == F3_ADD) dec.op = OP_SUB;
					else if (f7 == F7_ALT && f3 == F3_SR) dec.op = OP_SRA;
				end
			end
			OPC_BRANCH: begin
				dec.rs1    = rs1;
				dec.rs2    = rs2;
				dec.cls    = CLS_BRANCH;
				dec.target = pc_s1 + bimm;
				if (rs2 == REG_ZERO && f3 == F3_BEQ) dec.op = OP_C_BEQZ;
				else if (rs2 == REG_ZERO && f3 == F3_BNE) dec.op = OP_C_BNEZ;
				else if (rs2 == REG_ZERO && f3 == F3_BLT) dec.op = OP_P_BLTZ;
				else if (rs2 == REG_ZERO && f3 == F3_BGE) dec.op = OP_P_BGEZ;
				else if (rs1 == REG_ZERO && f3 == F3_BLT) dec.op = OP_P_BGTZ;
				else if (rs1 == REG_ZERO && f3 == F3_BGE) dec.op = OP_P_BLEZ;
				else if (f3 == F3_BEQ) dec.op = OP_BEQ;
				else if (f3 == F3_BNE) dec.op = OP_BNE;
				else if (f3 == F3_BLT) dec.op = OP_BLT;
				else if (f3 == F3_BGE) dec.op = OP_BGE;
				else if (f3 == F3_BLTU) dec.op = OP_BLTU;
				else if (f3 == F3_BGEU) dec.op = OP_BGEU;
			end
			OPC_JALR: begin
				dec.rs1     = rs1;
				dec.imm_b   = iimm;
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				dec.cls     = CLS_INDIRECT;
				if (iimm == 32'd0 && rs1 == REG_RA && rd == REG_ZERO) dec.op = OP_P_RET;
				else if (iimm == 32'd0 && rd == REG_ZERO) dec.op = OP_C_JR;
				else dec.op = OP_JALR;
			end
			OPC_TRAP: begin
				dec.op = OP_TRAP;
			end
			OPC_JAL: begin
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				dec.cls     = CLS_JUMP;
				dec.imm_b   = pc_s1 + 32'd4;
				dec.imm_a   = pc_s1 + jimm;
				dec.target  = pc_s1 + jimm;
				if (rd == REG_ZERO) dec.op = OP_C_J;
				else if (rd == REG_RA) dec.op = OP_C_JAL;
				else dec.op = OP_JAL;
			end
			OPC_SYSTEM: begin
				dec.rs1     = rs1;
				dec.imm_b   = {20'd0, sys_imm};
				dec.rd      = rd;
				dec.discard = (rd == REG_ZERO);
				if (f3 == F3_PRIV && sys_imm == SYS_ECALL) begin
					dec.op  = OP_ECALL;
					dec.cls = CLS_INDIRECT;
				end else if (f3 == F3_PRIV && sys_imm == SYS_SRET) begin
					dec.op  = OP_SRET;
					dec.cls = CLS_INDIRECT;
				end else if (f3 == F3_PRIV && sys_imm == SYS_SFENCE) dec.op = OP_SFENCE_VMA;
				else if (f3 == F3_CSRRW) dec.op = OP_CSRRW;
				else if (f3 == F3_CSRRS) dec.op = OP_CSRRS;
			end
			default: begin
				dec.op = OP_INV;
			end
		endcase
		if (dec.op == OP_INV) begin
			dec     = '0;
			dec.op  = OP_INV;
			dec.cls = CLS_NORMAL;
		end
	end

	assign done          = valid_s2;
	assign op_id         = res_s2.op;
	assign rs1_index     = res_s2.rs1;
	assign rs2_index     = res_s2.rs2;
	assign rd_index      = res_s2.rd;
	assign write_discard = res_s2.discard;
	assign imm_a         = res_s2.imm_a;
	assign imm_b         = res_s2.imm_b;
	assign instr_class   = res_s2.cls;
	assign jump_target   = res_s2.target;

endmodule
